[rtl/mbd_pkg.sv]
package mbd_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned CountW    = 32;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned RegIdxW   = 2;

  localparam logic [RegIdxW-1:0] RegDebounce  = 2'd0;
  localparam logic [RegIdxW-1:0] RegLongPress = 2'd1;
  localparam logic [RegIdxW-1:0] RegInterval  = 2'd2;

  localparam logic [DebounceW-1:0] DebounceRst  = 16'd50;
  localparam logic [TimeW-1:0]     LongPressRst = 32'd5000;
  localparam logic [TimeW-1:0]     IntervalRst  = 32'd0;

  typedef struct packed {
    logic             level;
    logic [TimeW-1:0] edge_time;
    logic [TimeW-1:0] press_start;
    logic [TimeW-1:0] release_time;
  } entry_t;

endpackage

[rtl/multi_button_debouncer_long_press.sv]
// Debounces up to BUTTON_COUNT buttons whose per-button state (level, last edge time, press start
// and release time) lives in a small synchronous memory. Each item names the buttons that saw an
// edge; they are visited in ascending order, one per clock cycle unless the output stalls,
// through a read-modify-write of that memory. An item with update_busy_i high or an empty
// mask is taken and causes nothing. The next item is taken as soon as the last button of the
// current one is issued. Each accepted change gives one result; the last result of an item
// carries last_o. A result passes from the button register to the pending register and then
// to the output register, and waits in the pending register until the remaining buttons of
// its item show whether it is the last one. Registers are written over the APB port at byte
// addresses 0, 4 and 8 by the user, only while the block is idle; the block does not enforce it.
module multi_button_debouncer_long_press #(
  parameter int unsigned BUTTON_COUNT = 7
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [BUTTON_COUNT-1:0]               edge_mask_i,
  input  logic [BUTTON_COUNT-1:0]               levels_i,
  input  logic [mbd_pkg::TimeW-1:0]             time_ms_i,
  input  logic                                  update_busy_i,

  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [((BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1)-1:0] button_o,
  output logic                                  level_o,
  output logic                                  update_request_o,
  output logic [mbd_pkg::CountW-1:0]            press_count_o,
  output logic                                  last_o,

  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mbd_pkg::CfgAddrW-1:0]          paddr,
  input  logic [mbd_pkg::CfgDataW-1:0]          pwdata,
  output logic [mbd_pkg::CfgDataW-1:0]          prdata,
  output logic                                  pready
);

  localparam int unsigned IdxW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  // Configuration registers.
  logic [mbd_pkg::DebounceW-1:0] dbc_q;
  logic [mbd_pkg::TimeW-1:0]     long_q;
  logic [mbd_pkg::TimeW-1:0]     intv_q;
  logic                          cfg_we;
  logic [mbd_pkg::RegIdxW-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[mbd_pkg::CfgAddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbc_q  <= mbd_pkg::DebounceRst;
      long_q <= mbd_pkg::LongPressRst;
      intv_q <= mbd_pkg::IntervalRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mbd_pkg::RegDebounce:  dbc_q  <= pwdata[mbd_pkg::DebounceW-1:0];
        mbd_pkg::RegLongPress: long_q <= pwdata;
        mbd_pkg::RegInterval:  intv_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mbd_pkg::RegDebounce:  prdata = {{(mbd_pkg::CfgDataW-mbd_pkg::DebounceW){1'b0}}, dbc_q};
      mbd_pkg::RegLongPress: prdata = long_q;
      mbd_pkg::RegInterval:  prdata = intv_q;
      default:               prdata = '0;
    endcase
  end

  // Item register and button issue.
  logic                      item_vld_q;
  logic [BUTTON_COUNT-1:0]   item_mask_q;
  logic [BUTTON_COUNT-1:0]   item_lvl_q;
  logic [mbd_pkg::TimeW-1:0] item_time_q;
  logic [IdxW-1:0]           issue_idx;
  logic [BUTTON_COUNT-1:0]   issue_rem;
  logic                      issue_end;
  logic                      issue;
  logic                      in_fire;

  logic                      b_vld_q;
  logic                      b_load;
  logic                      b_adv;

  always_comb begin
    issue_idx = '0;
    for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
      if (item_mask_q[i]) begin
        issue_idx = IdxW'(i);
      end
    end
    issue_rem            = item_mask_q;
    issue_rem[issue_idx] = 1'b0;
  end

  assign issue_end  = (issue_rem == '0);
  assign b_load     = !b_vld_q || b_adv;
  assign issue      = item_vld_q && b_load;
  assign in_stall_o = item_vld_q && !(issue && issue_end);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_fire && !update_busy_i && (edge_mask_i != '0)) begin
      item_vld_q <= 1'b1;
    end else if (issue && issue_end) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_mask_q <= edge_mask_i;
      item_lvl_q  <= levels_i;
      item_time_q <= time_ms_i;
    end else if (issue) begin
      item_mask_q <= issue_rem;
    end
  end

  // State memory with write-to-read bypass on the registered read port.
  mbd_pkg::entry_t           mem_q [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0]   ent_vld_q;
  mbd_pkg::entry_t           rd_q;
  logic                      rd_vld_q;
  logic                      mem_we;
  mbd_pkg::entry_t           wdata;

  logic [IdxW-1:0]           b_idx_q;
  logic                      b_lvl_q;
  logic [mbd_pkg::TimeW-1:0] b_time_q;
  logic                      b_end_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[b_idx_q] <= wdata;
    end
    if (issue) begin
      if (mem_we && (b_idx_q == issue_idx)) begin
        rd_q <= wdata;
      end else begin
        rd_q <= mem_q[issue_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_q[b_idx_q] <= 1'b1;
      end
      if (issue) begin
        rd_vld_q <= ent_vld_q[issue_idx] || (mem_we && (b_idx_q == issue_idx));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_load) begin
      b_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_idx_q  <= issue_idx;
      b_lvl_q  <= item_lvl_q[issue_idx];
      b_time_q <= item_time_q;
      b_end_q  <= issue_end;
    end
  end

  // Update of one button.
  mbd_pkg::entry_t           cur;
  logic                      changed;
  logic                      accepted;
  logic                      emit;
  logic                      req;
  logic [mbd_pkg::CountW-1:0] count_q;
  logic [mbd_pkg::CountW-1:0] count_d;

  assign cur      = rd_vld_q ? rd_q : '0;
  assign changed  = (b_lvl_q != cur.level);
  assign accepted = (b_time_q - cur.edge_time) >
                    {{(mbd_pkg::TimeW-mbd_pkg::DebounceW){1'b0}}, dbc_q};
  assign emit     = b_vld_q && changed && accepted;
  assign req      = !b_lvl_q && ((b_time_q - cur.press_start) > long_q) &&
                    ((cur.release_time - cur.press_start) > intv_q);
  assign count_d  = count_q + 1'b1;

  always_comb begin
    wdata              = cur;
    wdata.level        = b_lvl_q;
    wdata.edge_time    = b_time_q;
    if (accepted && b_lvl_q) begin
      wdata.press_start = b_time_q;
    end
    if (accepted && !b_lvl_q) begin
      wdata.release_time = b_time_q;
    end
  end

  assign mem_we = b_adv && changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (b_adv && emit) begin
      count_q <= count_d;
    end
  end

  // A result waits in the pending register until it is known whether it ends its item.
  logic                       p_vld_q;
  logic                       p_final_q;
  logic [IdxW-1:0]            p_btn_q;
  logic                       p_lvl_q;
  logic                       p_req_q;
  logic [mbd_pkg::CountW-1:0] p_cnt_q;
  logic                       out_vld_q;
  logic                       out_free;
  logic                       p_drain;

  assign out_free = !out_vld_q || !out_stall_i;
  assign p_drain  = p_vld_q && out_free && (p_final_q || emit);
  assign b_adv    = b_vld_q && (!emit || !p_vld_q || p_drain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q   <= 1'b0;
      p_final_q <= 1'b0;
    end else if (b_adv && emit) begin
      p_vld_q   <= 1'b1;
      p_final_q <= b_end_q;
    end else if (p_drain) begin
      p_vld_q   <= 1'b0;
    end else if (b_adv && b_end_q && p_vld_q) begin
      p_final_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && emit) begin
      p_btn_q <= b_idx_q;
      p_lvl_q <= b_lvl_q;
      p_req_q <= req;
      p_cnt_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (p_drain) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_drain) begin
      button_o         <= p_btn_q;
      level_o          <= p_lvl_q;
      update_request_o <= p_req_q;
      press_count_o    <= p_cnt_q;
      last_o           <= p_final_q && !(emit && !p_final_q);
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

[tb/mbd_checker.sv]
`timescale 1ns / 100ps

module mbd_checker #(
  parameter int unsigned BUTTON_COUNT = 7,
  parameter int unsigned BtnW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [BUTTON_COUNT-1:0]         edge_mask_i,
  input  logic [BUTTON_COUNT-1:0]         levels_i,
  input  logic [mbd_pkg::TimeW-1:0]       time_ms_i,
  input  logic                            update_busy_i,

  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [BtnW-1:0]                 button_i,
  input  logic                            level_i,
  input  logic                            update_request_i,
  input  logic [mbd_pkg::CountW-1:0]      press_count_i,
  input  logic                            last_i,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbd_pkg::CfgAddrW-1:0]    paddr,
  input  logic [mbd_pkg::CfgDataW-1:0]    pwdata,
  input  logic                            pready,

  output int unsigned                     pending_o,
  output int unsigned                     mismatches_o
);

  import mbd_pkg::*;

  typedef struct packed {
    logic [BtnW-1:0]   button;
    logic              level;
    logic              update_request;
    logic [CountW-1:0] press_count;
    logic              last;
  } change_t;

  logic [DebounceW-1:0]    debounce_cfg;
  logic [TimeW-1:0]        long_press_cfg;
  logic [TimeW-1:0]        interval_cfg;
  logic [BUTTON_COUNT-1:0] level_mem;
  logic [TimeW-1:0]        edge_mem [BUTTON_COUNT];
  logic [TimeW-1:0]        press_mem [BUTTON_COUNT];
  logic [TimeW-1:0]        release_mem [BUTTON_COUNT];
  logic [CountW-1:0]       change_total;
  change_t                 expected_changes [$];
  change_t                 seen;
  int unsigned             mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic debounce_buttons(input logic [BUTTON_COUNT-1:0] mask,
                                  input logic [BUTTON_COUNT-1:0] lv,
                                  input logic [TimeW-1:0] now);
    change_t          found [BUTTON_COUNT];
    logic [TimeW-1:0] gap;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] span;
    int               n_new;
    n_new = 0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (mask[i] && lv[i] != level_mem[i]) begin
        level_mem[i] = lv[i];
        gap = now - edge_mem[i];
        if (gap > TimeW'(debounce_cfg)) begin
          held = now - press_mem[i];
          span = release_mem[i] - press_mem[i];
          found[n_new].update_request = !lv[i] && held > long_press_cfg && span > interval_cfg;
          if (lv[i]) begin
            press_mem[i] = now;
          end else begin
            release_mem[i] = now;
          end
          change_total = change_total + 1'b1;
          found[n_new].button = BtnW'(i);
          found[n_new].level = lv[i];
          found[n_new].press_count = change_total;
          n_new++;
        end
        edge_mem[i] = now;
      end
    end
    for (int k = 0; k < n_new; k++) begin
      found[k].last = (k == n_new - 1);
      expected_changes.push_back(found[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_cfg = DebounceRst;
      long_press_cfg = LongPressRst;
      interval_cfg = IntervalRst;
      level_mem = '0;
      change_total = '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        edge_mem[i] = '0;
        press_mem[i] = '0;
        release_mem[i] = '0;
      end
      expected_changes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CfgAddrW-1:2])
          RegDebounce:  debounce_cfg = pwdata[DebounceW-1:0];
          RegLongPress: long_press_cfg = pwdata;
          RegInterval:  interval_cfg = pwdata;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_changes.size() == 0) begin
          $error("unexpected item for button %0d", button_i);
          mismatches++;
        end else begin
          seen = expected_changes.pop_front();
          check_field("button", 32'(seen.button), 32'(button_i));
          check_field("level", 32'(seen.level), 32'(level_i));
          check_field("update_request", 32'(seen.update_request), 32'(update_request_i));
          check_field("press_count", seen.press_count, press_count_i);
          check_field("last", 32'(seen.last), 32'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i && !update_busy_i) begin
        debounce_buttons(edge_mask_i, levels_i, time_ms_i);
      end
    end
    pending_o <= expected_changes.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  import mbd_pkg::*;

  localparam int unsigned ButtonCount = 7;
  localparam int unsigned BtnW = $clog2(ButtonCount);
  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned ItemsPerPhase = 28;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_stall;
  logic [ButtonCount-1:0] edge_mask;
  logic [ButtonCount-1:0] levels;
  logic [TimeW-1:0]       time_ms;
  logic                   update_busy;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [BtnW-1:0]        button;
  logic                   level;
  logic                   update_request;
  logic [CountW-1:0]      press_count;
  logic                   last;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CfgAddrW-1:0]    paddr;
  logic [CfgDataW-1:0]    pwdata;
  logic [CfgDataW-1:0]    prdata;
  logic                   pready;

  int unsigned            pending_changes;
  int unsigned            mismatches;
  int unsigned            cycle_count = 0;
  int unsigned            stall_left = 0;
  bit                     calm = 1'b0;
  logic [ButtonCount-1:0] held_levels;
  logic [TimeW-1:0]       now_ms;
  int unsigned            debounce_set;
  logic [TimeW-1:0]       long_press_set;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  multi_button_debouncer_long_press #(
    .BUTTON_COUNT(ButtonCount)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .edge_mask_i     (edge_mask),
    .levels_i        (levels),
    .time_ms_i       (time_ms),
    .update_busy_i   (update_busy),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .button_o        (button),
    .level_o         (level),
    .update_request_o(update_request),
    .press_count_o   (press_count),
    .last_o          (last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  mbd_checker #(
    .BUTTON_COUNT(ButtonCount)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .edge_mask_i     (edge_mask),
    .levels_i        (levels),
    .time_ms_i       (time_ms),
    .update_busy_i   (update_busy),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .button_i        (button),
    .level_i         (level),
    .update_request_i(update_request),
    .press_count_i   (press_count),
    .last_i          (last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .pending_o       (pending_changes),
    .mismatches_o    (mismatches)
  );

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegDebounce:  debounce_set = value[DebounceW-1:0];
      RegLongPress: long_press_set = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic [ButtonCount-1:0] mask, input logic [ButtonCount-1:0] lv,
                           input logic [TimeW-1:0] stamp, input logic busy);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    edge_mask <= mask;
    levels <= lv;
    time_ms <= stamp;
    update_busy <= busy;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (!busy) begin
      held_levels = (held_levels & ~mask) | (lv & mask);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_changes != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic rand_item();
    logic [ButtonCount-1:0] flips;
    logic [ButtonCount-1:0] extra;
    logic [ButtonCount-1:0] mask;
    logic [ButtonCount-1:0] lv;
    logic                   busy;
    int unsigned            pick;
    int unsigned            long_cap;
    int unsigned            step;
    flips = '0;
    extra = '0;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      busy = 1'($urandom_range(0, 1));
      send_item(ButtonCount'($urandom), ButtonCount'($urandom), $urandom, busy);
    end else begin
      for (int i = 0; i < ButtonCount; i++) begin
        if ($urandom_range(0, 9) < 3) flips[i] = 1'b1;
        if ($urandom_range(0, 9) == 0) extra[i] = 1'b1;
      end
      if (flips == '0) flips[$urandom_range(0, ButtonCount - 1)] = 1'b1;
      mask = flips | extra;
      lv = (held_levels ^ flips) ^ (ButtonCount'($urandom) & ~mask);
      long_cap = (long_press_set > 20000) ? 20000 : long_press_set;
      if (pick < 45) begin
        step = $urandom_range(0, 2 * debounce_set + 4);
      end else if (pick < 85) begin
        step = $urandom_range(0, 2 * long_cap + 4);
      end else begin
        step = $urandom_range(0, 200000);
      end
      now_ms = now_ms + step;
      busy = ($urandom_range(0, 19) == 0);
      send_item(mask, lv, now_ms, busy);
    end
  endtask

  task automatic random_phase(input int unsigned count);
    for (int n = 0; n < count; n++) begin
      if (!calm && $urandom_range(0, 24) == 0) drain();
      rand_item();
    end
    drain();
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    edge_mask <= '0;
    levels <= '0;
    time_ms <= '0;
    update_busy <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    held_levels = '0;
    now_ms = '0;
    debounce_set = DebounceRst;
    long_press_set = LongPressRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(7'h7f, 7'h7f, 32'd1000, 1'b1);
    send_item(7'h00, 7'h7f, 32'd1000, 1'b0);
    send_item(7'h7f, 7'h00, 32'd1000, 1'b0);
    send_item(7'h7f, 7'h7f, 32'd1000, 1'b0);
    send_item(7'h01, 7'h00, 32'd1020, 1'b0);
    send_item(7'h01, 7'h01, 32'd1070, 1'b0);
    send_item(7'h01, 7'h00, 32'd1121, 1'b0);
    send_item(7'h02, 7'h00, 32'd6000, 1'b0);
    send_item(7'h04, 7'h00, 32'd6001, 1'b0);
    send_item(7'h7f, 7'h00, 32'd6100, 1'b1);
    send_item(7'h78, 7'h00, 32'hffff_fff0, 1'b0);
    send_item(7'h7f, 7'h55, 32'h0000_0010, 1'b0);
    send_item(7'h7f, 7'h2a, 32'h0000_0100, 1'b0);
    send_item(7'h7f, 7'h7f, 32'h0001_0000, 1'b0);
    send_item(7'h7f, 7'h00, 32'h7fff_ffff, 1'b0);
    send_item(7'h40, 7'h40, 32'h8000_0000, 1'b0);
    send_item(7'h40, 7'h00, 32'h8000_0032, 1'b0);
    send_item(7'h40, 7'h40, 32'h8000_0065, 1'b0);
    send_item(7'h2a, 7'h7f, 32'ha5a5_a5a5, 1'b0);
    send_item(7'h55, 7'h00, 32'h5a5a_5a5a, 1'b0);
    drain();
    now_ms = 32'h5a5a_5a5a;

    cfg_write(RegDebounce, 32'd0);
    cfg_write(RegLongPress, 32'd0);
    cfg_write(RegInterval, 32'd0);
    random_phase(ItemsPerPhase);

    cfg_write(RegDebounce, 32'h0000_ffff);
    cfg_write(RegLongPress, 32'hffff_ffff);
    cfg_write(RegInterval, 32'hffff_ffff);
    now_ms = 32'hffff_0000;
    random_phase(ItemsPerPhase);

    cfg_write(RegDebounce, $urandom_range(10, 200));
    cfg_write(RegLongPress, $urandom_range(100, 3000));
    cfg_write(RegInterval, $urandom_range(0, 3000));
    random_phase(ItemsPerPhase);

    // No idling on either side here, and only presses that begin soon after an earlier release
    // can pass the interval test.
    calm = 1'b1;
    cfg_write(RegDebounce, 32'd50);
    cfg_write(RegLongPress, 32'd1000);
    cfg_write(RegInterval, 32'hffff_0000);
    random_phase(ItemsPerPhase);
    calm = 1'b0;

    if (mismatches == 0 && pending_changes == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
